>>> hdl/nlc_pkg.sv
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared constants, op codes and word helpers for the newline locator.
// ----------------------------------------------------------------------------
package nlc_pkg;

    localparam int MAP_WORDS_DEF = 256;
    localparam int POS_W         = 14;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int CNT_W         = 7;
    localparam int OP_W          = 2;

    localparam logic [OP_W-1:0] OP_MARK   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

    function automatic logic [CNT_W-1:0] popcount(input word_t w);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            cnt = cnt + CNT_W'(w[i]);
        end
        return cnt;
    endfunction

    function automatic logic [BIT_W-1:0] highest_set(input word_t w);
        logic [BIT_W-1:0] hi;
        hi = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                hi = BIT_W'(i);
            end
        end
        return hi;
    endfunction

endpackage

>>> hdl/nlc_ram.sv
// ----------------------------------------------------------------------------
// nlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/newline_bitmap_line_column_locator.sv
// ----------------------------------------------------------------------------
// newline_bitmap_line_column_locator
// Newline bitmap with mark, clear and line/column locate operations.
// ----------------------------------------------------------------------------
// Op codes on s_tuser: mark sets the bit for a position, clear empties the
// map, locate returns the newline count strictly below a position and the
// column since the last newline below it. The map lives in a RAM of
// MAP_WORDS 64-bit words with one valid flop per word, so clear just resets
// the valid flops and no sweep after reset is needed. Mark reads the word,
// then writes it back. Locate walks words 0 up to the position's word (the
// last word for a position beyond the map) through one popcount/priority
// unit, one word per cycle behind the RAM read latency. The block takes
// no new transfer while an operation is in progress.
module newline_bitmap_line_column_locator #(
    parameter int MAP_WORDS = nlc_pkg::MAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [13:0] position
    input  logic [nlc_pkg::OP_W-1:0]    s_tuser,   // [1:0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata    // [13:0] line, [27:14] column
);
    import nlc_pkg::*;

    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_WORD = MAP_WORDS - 1;
    localparam int PW_W      = POS_W - BIT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MWR  = 2'd1;
    localparam logic [1:0] ST_LOC  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [MAP_WORDS-1:0]  valid_reg, valid_next;
    pos_t                  pos_reg, pos_next;
    logic                  beyond_reg, beyond_next;
    logic [WIDX_W-1:0]     end_reg, end_next;
    logic [WIDX_W-1:0]     issue_reg, issue_next;
    logic                  issuing_reg, issuing_next;
    logic [WIDX_W-1:0]     proc_word_reg, proc_word_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic                  vld_q_reg;
    pos_t                  line_reg, line_next;
    pos_t                  last_reg, last_next;
    logic                  found_reg, found_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    pos_t                  out_line_reg, out_line_next;
    pos_t                  out_col_reg, out_col_next;

    logic                  s_xfer;
    pos_t                  in_pos;
    logic [PW_W-1:0]       in_pw;
    logic                  in_beyond;
    logic [WIDX_W-1:0]     in_widx;
    logic [WIDX_W-1:0]     rd_addr;
    word_t                 rd_data;
    word_t                 word_eff;
    word_t                 mask;
    word_t                 masked;
    logic                  we;
    word_t                 wdata;
    logic [BIT_W-1:0]      hi_bit;

    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_pw     = in_pos[POS_W-1:BIT_W];
    assign in_beyond = (32'(in_pw) >= 32'(MAP_WORDS));
    assign in_widx   = WIDX_W'(32'(in_pw));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_col_reg, out_line_reg};

    assign rd_addr  = (state_reg == ST_IDLE) ? in_widx : issue_reg;
    assign word_eff = vld_q_reg ? rd_data : '0;

    always_comb
    begin
        if (beyond_reg || (proc_word_reg != end_reg))
        begin
            mask = '1;
        end
        else
        begin
            mask = (word_t'(1) << pos_reg[BIT_W-1:0]) - word_t'(1);
        end
    end

    assign masked = word_eff & mask;
    assign hi_bit = highest_set(masked);
    assign we     = (state_reg == ST_MWR);
    assign wdata  = word_eff | (word_t'(1) << pos_reg[BIT_W-1:0]);

    nlc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (WIDX_W)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (end_reg),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        pos_next        = pos_reg;
        beyond_next     = beyond_reg;
        end_next        = end_reg;
        issue_next      = issue_reg;
        issuing_next    = issuing_reg;
        proc_word_next  = proc_word_reg;
        proc_valid_next = 1'b0;
        line_next       = line_reg;
        last_next       = last_reg;
        found_next      = found_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_line_next   = out_line_reg;
        out_col_next    = out_col_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    pos_next    = in_pos;
                    beyond_next = in_beyond;
                    end_next    = in_beyond ? WIDX_W'(LAST_WORD) : in_widx;
                    case (s_tuser)
                        OP_MARK:
                        begin
                            if (!in_beyond)
                            begin
                                state_next = ST_MWR;
                            end
                        end
                        OP_LOCATE:
                        begin
                            state_next   = ST_LOC;
                            issue_next   = '0;
                            issuing_next = 1'b1;
                            line_next    = '0;
                            last_next    = '0;
                            found_next   = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MWR:
            begin
                valid_next[end_reg] = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_LOC:
            begin
                if (issuing_reg)
                begin
                    proc_valid_next = 1'b1;
                    proc_word_next  = issue_reg;
                    if (issue_reg == end_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_next = issue_reg + WIDX_W'(1);
                    end
                end
                if (proc_valid_reg)
                begin
                    line_next = line_reg + POS_W'(popcount(masked));
                    if (masked != '0)
                    begin
                        found_next = 1'b1;
                        last_next  = POS_W'((32'(proc_word_reg) << BIT_W) | 32'(hi_bit));
                    end
                    if (proc_word_reg == end_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_line_next = line_reg;
                    out_col_next  = found_reg ? (pos_reg - last_reg - POS_W'(1)) : pos_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            issuing_reg    <= 1'b0;
            proc_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issuing_reg    <= issuing_next;
            proc_valid_reg <= proc_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        beyond_reg    <= beyond_next;
        end_reg       <= end_next;
        issue_reg     <= issue_next;
        proc_word_reg <= proc_word_next;
        vld_q_reg     <= valid_reg[rd_addr];
        line_reg      <= line_next;
        last_reg      <= last_next;
        found_reg     <= found_next;
        out_line_reg  <= out_line_next;
        out_col_reg   <= out_col_next;
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_CLEAR)) |=> (valid_reg == '0))
        else $error("map not empty after clear");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

    a_proc_in_locate: assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == ST_LOC))
        else $error("word processed outside locate");

    a_last_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && found_reg) |-> (last_reg < pos_reg))
        else $error("last newline not below position");

endmodule

>>> sim/newline_bitmap_line_column_locator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newline_bitmap_line_column_locator_tb
// Self-checking bench for the newline bitmap locator. Mark, locate, clear and
// unused commands are streamed in with random gaps. A bit-level shadow of the
// map predicts each locate result (line, column), and every returned transfer
// is checked in order against those predictions.
// ----------------------------------------------------------------------------
module newline_bitmap_line_column_locator_tb;

    import nlc_pkg::*;

    localparam int MAP_BITS       = MAP_WORDS_DEF * WORD_W;
    localparam int RANDOM_CMDS    = 1200;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0] op;
        pos_t            position;
        bit              drain;
    } command_t;

    typedef struct {
        pos_t line;
        pos_t column;
    } location_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic [MAP_BITS-1:0] shadow_bits = '0;
    command_t            pending_cmds[$];
    location_t           expected_locs[$];
    command_t            next_cmd;

    int  send_gap     = 0;
    int  recv_stall   = 0;
    int  idle_cycles  = 0;
    int  mismatches   = 0;
    int  n_marks      = 0;
    int  n_locates    = 0;
    int  n_clears     = 0;
    int  n_ignored    = 0;
    int  n_checked    = 0;
    bit  steady_phase = 1'b0;
    bit  run_done     = 1'b0;

    newline_bitmap_line_column_locator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // shadow of the map; pushes the expected location for each locate
    function automatic void apply_command(logic [OP_W-1:0] op, pos_t pos);
        location_t loc;
        int        line_cnt;
        int        last_mark;
        line_cnt  = 0;
        last_mark = -1;
        case (op)
            OP_MARK:
            begin
                n_marks++;
                if (int'(pos) < MAP_BITS)
                    shadow_bits[pos] = 1'b1;
            end
            OP_CLEAR:
            begin
                n_clears++;
                shadow_bits = '0;
            end
            OP_LOCATE:
            begin
                n_locates++;
                for (int i = 0; i < int'(pos); i++)
                begin
                    if (i < MAP_BITS && shadow_bits[i])
                    begin
                        line_cnt++;
                        last_mark = i;
                    end
                end
                loc.line   = pos_t'(line_cnt);
                loc.column = (last_mark < 0) ? pos : pos_t'(int'(pos) - last_mark - 1);
                expected_locs.push_back(loc);
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endfunction

    function automatic void check_location(logic [31:0] data);
        location_t exp_loc;
        pos_t      got_line;
        pos_t      got_column;
        got_line   = data[13:0];
        got_column = data[27:14];
        if (expected_locs.size() == 0)
        begin
            $error("result with nothing expected: line %0d column %0d", got_line, got_column);
            mismatches++;
            return;
        end
        exp_loc = expected_locs.pop_front();
        n_checked++;
        if (got_line !== exp_loc.line)
        begin
            $error("line: expected %0d, got %0d", exp_loc.line, got_line);
            mismatches++;
        end
        if (got_column !== exp_loc.column)
        begin
            $error("column: expected %0d, got %0d", exp_loc.column, got_column);
            mismatches++;
        end
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, int pos, bit drain = 1'b0);
        command_t c;
        c.op       = op;
        c.position = pos_t'(pos);
        c.drain    = drain;
        pending_cmds.push_back(c);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tuser, s_tdata[13:0]);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && expected_locs.size() > 0))
                begin
                    next_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_cmd.op;
                    s_tdata  <= {2'b00, next_cmd.position};
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_location(m_tdata);
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    // watchdog; also flips between idle-free stretches and gappy ones
    always @(posedge clk)
    begin
        if (rst_n && !run_done)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 299) == 0)
                steady_phase <= !steady_phase;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int issued;
        int region;
        int pos;
        int r;
        logic [OP_W-1:0] op;

        // directed
        queue_cmd(OP_CLEAR, 0);
        queue_cmd(OP_LOCATE, 0);
        queue_cmd(OP_LOCATE, 16383);
        queue_cmd(OP_MARK, 0);
        queue_cmd(OP_LOCATE, 0);
        queue_cmd(OP_LOCATE, 1);
        queue_cmd(OP_MARK, 0);
        queue_cmd(OP_LOCATE, 1);
        queue_cmd(OP_MARK, 63);
        queue_cmd(OP_MARK, 64);
        queue_cmd(OP_LOCATE, 64);
        queue_cmd(OP_LOCATE, 65);
        queue_cmd(OP_MARK, 16383);
        queue_cmd(OP_LOCATE, 16383);
        queue_cmd(OP_MARK, 16382);
        queue_cmd(OP_LOCATE, 16383, 1'b1);
        queue_cmd(OP_UNUSED, 5);
        queue_cmd(OP_LOCATE, 5);
        queue_cmd(OP_MARK, 14'h2AAA);
        queue_cmd(OP_MARK, 14'h1555);
        queue_cmd(OP_LOCATE, 14'h2AAA);
        queue_cmd(OP_LOCATE, 14'h3FFF);
        queue_cmd(OP_CLEAR, 14'h3FFF);
        queue_cmd(OP_LOCATE, 16383);

        // random: marks, locates, clears and unused ops, mostly in a moving window
        issued = 0;
        region = $urandom_range(0, 16383);
        while (issued < RANDOM_CMDS)
        begin
            if ($urandom_range(0, 39) == 0)
                region = $urandom_range(0, 16383);
            r = $urandom_range(0, 99);
            if (r < 70)
                pos = (region + $urandom_range(0, 511)) % 16384;
            else if (r < 85)
                pos = $urandom_range(0, 16383);
            else if (r < 95)
                pos = $urandom_range(0, 200);
            else
                pos = ($urandom_range(0, 1) == 0) ? 0 : 16383;
            r = $urandom_range(0, 999);
            if (r < 500)
                op = OP_MARK;
            else if (r < 960)
                op = OP_LOCATE;
            else if (r < 970)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            queue_cmd(op, pos, $urandom_range(0, 199) == 0);
            if (op != OP_UNUSED)
                issued++;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_locs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        run_done = 1'b1;

        $display("covered %0d marks, %0d locates, %0d clears, %0d unused ops",
                 n_marks, n_locates, n_clears, n_ignored);
        $display("checked %0d locate results, %0d field mismatches", n_checked, mismatches);
        if (mismatches == 0 && expected_locs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
